[hw/rtl/fpjs_pkg.sv]
// Shared constants and types for the frame pacing and jitter statistics block.
`default_nettype none
package fpjs_pkg;

    localparam int HISTORY_DEPTH = 64;
    localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W         = 32 + $clog2(HISTORY_DEPTH);
    localparam int DIV_CNT_W     = $clog2(SUM_W);
    localparam int PROD_W        = 42;
    localparam int CFG_IDX_W     = 8;

    localparam logic [31:0] TARGET_RESET  = 32'd16666;
    localparam logic [31:0] STUTTER_RESET = 32'd25000;
    localparam logic [9:0]  US_PER_MS     = 10'd1000;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_IDX  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STUTTER_IDX = 8'd1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_UPD  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

endpackage
`default_nettype wire

[hw/rtl/fpjs_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module fpjs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[hw/rtl/frame_pacing_jitter_stats.sv]
// Top level of the frame pacing and jitter statistics block.
`default_nettype none
// Each accepted frame-end timestamp yields one result. The tick difference is
// registered at the accepting edge. Then the multiply by 1000 is registered
// while the history RAM is read, and after that the statistics are updated and
// the history entry is written back. The bit-serial dividers then form both
// window averages (one quotient bit per cycle), and then the output register
// is loaded. The input is ready again in the cycle in which the result
// appears. One item is in work at a time. A new timestamp is taken while a
// finished result still waits at the output, and its own result then holds
// until that result is taken. History entries are read only once the window
// has filled, so the history RAM needs no clearing after reset.
module frame_pacing_jitter_stats (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [fpjs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [31:0]                    i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [31:0]                    i_now_ms,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic      [31:0]                    o_frame_us,
    output logic      [31:0]                    o_jit_delta,
    output logic signed [32:0]                  o_pace_err,
    output logic      [31:0]                    o_frame_min,
    output logic      [31:0]                    o_frame_max,
    output logic      [31:0]                    o_jit_peak,
    output logic      [31:0]                    o_stutter_total,
    output logic      [31:0]                    o_frame_total,
    output logic      [31:0]                    o_frame_mean,
    output logic      [31:0]                    o_jit_mean
);
    import fpjs_pkg::*;

    t_state r_state;

    logic [31:0] r_target, r_stutter_thr;
    logic [31:0] r_last_tick, r_prev_frame;
    logic [31:0] r_min, r_max, r_max_jit;
    logic [31:0] r_stutter_cnt, r_frame_cnt;
    logic [SLOT_W-1:0] r_slot;
    logic [SUM_W-1:0]  r_fsum, r_jsum;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    logic [31:0]       r_delta;
    logic [PROD_W-1:0] r_prod;
    logic [31:0]       r_frame, r_jitter;
    logic [32:0]       r_perr;
    logic [SUM_W-1:0]  r_fq, r_jq;
    logic [CNT_W-1:0]  r_frem, r_jrem, r_div;

    logic [63:0] ram_rdata;
    logic        ram_we;

    logic [31:0]      n_frame, frame_sat, n_jitter, n_frame_cnt;
    logic             window_full;
    logic [SUM_W-1:0] n_fsum, n_jsum, old_f, old_j;
    logic [CNT_W-1:0] n_filled;
    logic [CNT_W:0]   ft, jt;
    logic             fge, jge;

    assign o_in_ready = (r_state == S_IDLE);
    assign ram_we     = (r_state == S_UPD);

    fpjs_ram #(
        .WIDTH (64),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata ({n_jitter, n_frame}),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        frame_sat   = (|r_prod[PROD_W-1:32]) ? 32'hFFFF_FFFF : r_prod[31:0];
        n_frame     = (frame_sat == 32'd0) ? r_target : frame_sat;
        n_jitter    = (n_frame > r_prev_frame) ? n_frame - r_prev_frame
                                               : r_prev_frame - n_frame;
        window_full = (r_frame_cnt >= 32'(HISTORY_DEPTH));
        n_frame_cnt = (r_frame_cnt == 32'hFFFF_FFFF) ? r_frame_cnt : r_frame_cnt + 32'd1;
        old_f       = window_full ? SUM_W'(ram_rdata[31:0])  : '0;
        old_j       = window_full ? SUM_W'(ram_rdata[63:32]) : '0;
        n_fsum      = r_fsum - old_f + SUM_W'(n_frame);
        n_jsum      = r_jsum - old_j + SUM_W'(n_jitter);
        n_filled    = (n_frame_cnt < 32'(HISTORY_DEPTH)) ? n_frame_cnt[CNT_W-1:0]
                                                         : CNT_W'(HISTORY_DEPTH);
        ft  = {r_frem, r_fq[SUM_W-1]};
        jt  = {r_jrem, r_jq[SUM_W-1]};
        fge = (ft >= {1'b0, r_div});
        jge = (jt >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_target      <= TARGET_RESET;
            r_stutter_thr <= STUTTER_RESET;
            r_last_tick   <= '0;
            r_prev_frame  <= TARGET_RESET;
            r_min         <= 32'hFFFF_FFFF;
            r_max         <= '0;
            r_max_jit     <= '0;
            r_stutter_cnt <= '0;
            r_frame_cnt   <= '0;
            r_slot        <= '0;
            r_fsum        <= '0;
            r_jsum        <= '0;
            r_div_cnt     <= '0;
            o_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TARGET_IDX:  r_target      <= i_cfg_data;
                    CFG_STUTTER_IDX: r_stutter_thr <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_DONE && (!o_out_valid || i_out_ready)) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_last_tick <= i_now_ms;
                        r_state     <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_prev_frame <= n_frame;
                    r_frame_cnt  <= n_frame_cnt;
                    r_fsum       <= n_fsum;
                    r_jsum       <= n_jsum;
                    if (n_frame < r_min) begin
                        r_min <= n_frame;
                    end
                    if (n_frame > r_max) begin
                        r_max <= n_frame;
                    end
                    if (n_jitter > r_max_jit) begin
                        r_max_jit <= n_jitter;
                    end
                    if (n_frame > r_stutter_thr && r_stutter_cnt != 32'hFFFF_FFFF) begin
                        r_stutter_cnt <= r_stutter_cnt + 32'd1;
                    end
                    r_slot    <= (r_slot == SLOT_W'(HISTORY_DEPTH - 1)) ? '0
                                                                        : r_slot + 1'b1;
                    r_div_cnt <= '0;
                    r_state   <= S_DIV;
                end
                S_DIV: begin
                    r_div_cnt <= r_div_cnt + 1'b1;
                    if (r_div_cnt == DIV_CNT_W'(SUM_W - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!o_out_valid || i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_delta <= i_now_ms - r_last_tick;
            end
            S_MUL: begin
                r_prod <= PROD_W'(r_delta) * PROD_W'(US_PER_MS);
            end
            S_UPD: begin
                r_frame  <= n_frame;
                r_jitter <= n_jitter;
                r_perr   <= {1'b0, n_frame} - {1'b0, r_target};
                r_fq     <= n_fsum;
                r_jq     <= n_jsum;
                r_frem   <= '0;
                r_jrem   <= '0;
                r_div    <= n_filled;
            end
            S_DIV: begin
                r_fq   <= {r_fq[SUM_W-2:0], fge};
                r_jq   <= {r_jq[SUM_W-2:0], jge};
                r_frem <= fge ? CNT_W'(ft - {1'b0, r_div}) : ft[CNT_W-1:0];
                r_jrem <= jge ? CNT_W'(jt - {1'b0, r_div}) : jt[CNT_W-1:0];
            end
            S_DONE: begin
                if (!o_out_valid || i_out_ready) begin
                    o_frame_us      <= r_frame;
                    o_jit_delta     <= r_jitter;
                    o_pace_err      <= r_perr;
                    o_frame_min     <= r_min;
                    o_frame_max     <= r_max;
                    o_jit_peak      <= r_max_jit;
                    o_stutter_total <= r_stutter_cnt;
                    o_frame_total   <= r_frame_cnt;
                    o_frame_mean    <= r_fq[31:0];
                    o_jit_mean      <= r_jq[31:0];
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

[hw/rtl/fpjs_checker.sv]
// Port-level checker for the frame pacing and jitter statistics block, with its bind.
`default_nettype none
module fpjs_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_cfg_we,
    input wire logic [fpjs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input wire logic [31:0]                    i_cfg_data,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_ready,
    input wire logic [31:0]                    i_now_ms,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_ready,
    input wire logic [31:0]                    o_frame_us,
    input wire logic [31:0]                    o_jit_delta,
    input wire logic signed [32:0]             o_pace_err,
    input wire logic [31:0]                    o_frame_min,
    input wire logic [31:0]                    o_frame_max,
    input wire logic [31:0]                    o_jit_peak,
    input wire logic [31:0]                    o_stutter_total,
    input wire logic [31:0]                    o_frame_total,
    input wire logic [31:0]                    o_frame_mean,
    input wire logic [31:0]                    o_jit_mean
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_frame_us))
        else $error("result dropped or changed while stalled");

    a_frame_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_frame_min <= o_frame_us && o_frame_us <= o_frame_max)
        else $error("frame time outside min/max");

    a_jitter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_jit_delta <= o_jit_peak)
        else $error("jitter above max jitter");

    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_frame_total != 32'd0 && o_stutter_total <= o_frame_total)
        else $error("frame or stutter count inconsistent");

endmodule

bind frame_pacing_jitter_stats fpjs_checker u_fpjs_checker (.*);
`default_nettype wire

[verif/frame_pacing_jitter_stats_tb.sv]
// Self-checking testbench for the frame pacing and jitter statistics block.
`default_nettype none
module frame_pacing_jitter_stats_tb;
    import fpjs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESULT_LATENCY = SUM_W + 4;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED_IDX = '1;

    typedef struct {
        logic [31:0]        frame_us;
        logic [31:0]        jit_delta;
        logic signed [32:0] pace_err;
        logic [31:0]        frame_min;
        logic [31:0]        frame_max;
        logic [31:0]        jit_peak;
        logic [31:0]        stutter_total;
        logic [31:0]        frame_total;
        logic [31:0]        frame_mean;
        logic [31:0]        jit_mean;
    } t_frame_stats;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [31:0]          i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic [31:0]          i_now_ms   = '0;
    logic                 i_out_ready = 1'b0;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic [31:0]          o_frame_us;
    logic [31:0]          o_jit_delta;
    logic signed [32:0]   o_pace_err;
    logic [31:0]          o_frame_min;
    logic [31:0]          o_frame_max;
    logic [31:0]          o_jit_peak;
    logic [31:0]          o_stutter_total;
    logic [31:0]          o_frame_total;
    logic [31:0]          o_frame_mean;
    logic [31:0]          o_jit_mean;

    frame_pacing_jitter_stats uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_now_ms        (i_now_ms),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_frame_us      (o_frame_us),
        .o_jit_delta     (o_jit_delta),
        .o_pace_err      (o_pace_err),
        .o_frame_min     (o_frame_min),
        .o_frame_max     (o_frame_max),
        .o_jit_peak      (o_jit_peak),
        .o_stutter_total (o_stutter_total),
        .o_frame_total   (o_frame_total),
        .o_frame_mean    (o_frame_mean),
        .o_jit_mean      (o_jit_mean)
    );

    // Pacing statistics tracked alongside the block.
    logic [31:0]      cfg_target  = TARGET_RESET;
    logic [31:0]      cfg_stutter = STUTTER_RESET;
    logic [31:0]      prior_tick  = '0;
    logic [31:0]      prior_frame = TARGET_RESET;
    logic [31:0]      least_frame = '1;
    logic [31:0]      most_frame  = '0;
    logic [31:0]      most_jitter = '0;
    logic [31:0]      stutters    = '0;
    logic [31:0]      frames_seen = '0;
    int               ring_slot   = 0;
    logic [31:0]      frame_ring  [HISTORY_DEPTH];
    logic [31:0]      jitter_ring [HISTORY_DEPTH];
    logic [SUM_W-1:0] frame_total_us  = '0;
    logic [SUM_W-1:0] jitter_total_us = '0;

    t_frame_stats stats_due[$];
    logic [31:0]  tick_cursor   = '0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           mismatches    = 0;
    int           stall_cycles  = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void predict_frame_stats(input logic [31:0] tick);
        logic [31:0]  delta_ms;
        logic [63:0]  product;
        logic [31:0]  frame;
        logic [31:0]  jitter;
        logic         window_full;
        logic [63:0]  filled;
        t_frame_stats stats;
        delta_ms = tick - prior_tick;
        prior_tick = tick;
        product = 64'(delta_ms) * 64'(US_PER_MS);
        frame = (product > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : product[31:0];
        if (frame == 32'd0)
            frame = cfg_target;
        window_full = frames_seen >= HISTORY_DEPTH;
        if (frames_seen != 32'hFFFF_FFFF)
            frames_seen = frames_seen + 32'd1;
        jitter = (frame > prior_frame) ? frame - prior_frame : prior_frame - frame;
        prior_frame = frame;
        if (frame < least_frame)
            least_frame = frame;
        if (frame > most_frame)
            most_frame = frame;
        if (jitter > most_jitter)
            most_jitter = jitter;
        if (frame > cfg_stutter && stutters != 32'hFFFF_FFFF)
            stutters = stutters + 32'd1;
        if (window_full) begin
            frame_total_us  = frame_total_us - SUM_W'(frame_ring[ring_slot]);
            jitter_total_us = jitter_total_us - SUM_W'(jitter_ring[ring_slot]);
        end
        frame_ring[ring_slot]  = frame;
        jitter_ring[ring_slot] = jitter;
        frame_total_us  = frame_total_us + SUM_W'(frame);
        jitter_total_us = jitter_total_us + SUM_W'(jitter);
        ring_slot = (ring_slot + 1) % HISTORY_DEPTH;
        filled = (frames_seen < HISTORY_DEPTH) ? 64'(frames_seen) : 64'(HISTORY_DEPTH);

        stats.frame_us      = frame;
        stats.jit_delta     = jitter;
        stats.pace_err      = {1'b0, frame} - {1'b0, cfg_target};
        stats.frame_min     = least_frame;
        stats.frame_max     = most_frame;
        stats.jit_peak      = most_jitter;
        stats.stutter_total = stutters;
        stats.frame_total   = frames_seen;
        stats.frame_mean    = 32'(64'(frame_total_us) / filled);
        stats.jit_mean      = 32'(64'(jitter_total_us) / filled);
        stats_due.push_back(stats);
    endfunction

    function automatic void check_field(input string field, input logic [32:0] want,
                                        input logic [32:0] got);
        if (want !== got) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin : check_results
        t_frame_stats want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (stats_due.size() == 0) begin
                $display("%0t: result transfer with none expected, frame_us 0x%0h",
                         $time, o_frame_us);
                mismatches++;
            end else begin
                want = stats_due.pop_front();
                check_field("frame_us", 33'(want.frame_us), 33'(o_frame_us));
                check_field("jit_delta", 33'(want.jit_delta), 33'(o_jit_delta));
                check_field("pace_err", want.pace_err, o_pace_err);
                check_field("frame_min", 33'(want.frame_min), 33'(o_frame_min));
                check_field("frame_max", 33'(want.frame_max), 33'(o_frame_max));
                check_field("jit_peak", 33'(want.jit_peak), 33'(o_jit_peak));
                check_field("stutter_total", 33'(want.stutter_total), 33'(o_stutter_total));
                check_field("frame_total", 33'(want.frame_total), 33'(o_frame_total));
                check_field("frame_mean", 33'(want.frame_mean), 33'(o_frame_mean));
                check_field("jit_mean", 33'(want.jit_mean), 33'(o_jit_mean));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("frame_pacing_jitter_stats_tb: FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_tick(input logic [31:0] tick);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_now_ms   <= tick;
        do @(posedge i_clk); while (!o_in_ready);
        predict_frame_stats(tick);
        tick_cursor = tick;
        @(negedge i_clk);
    endtask

    task automatic drain_results;
        i_in_valid <= 1'b0;
        while (stats_due.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_TARGET_IDX)
            cfg_target = value;
        else if (idx == CFG_STUTTER_IDX)
            cfg_stutter = value;
        @(negedge i_clk);
    endtask

    task automatic test_first_frame_and_gaps;
        send_idle_pct = 37;
        recv_idle_pct = 74;
        send_tick(32'd17);
        send_tick(32'd17);
        send_tick(32'd34);
        send_tick(32'd34 + 32'd4294967);
        send_tick(tick_cursor + 32'd4294968);
        send_tick(32'hFFFF_FFFF);
        send_tick(32'd5);
        send_tick(32'd0);
        send_tick(32'hFFFF_FFFF);
        send_tick(32'h5555_5555);
        send_tick(32'hAAAA_AAAA);
        drain_results;
    endtask

    task automatic test_register_extremes;
        write_reg(CFG_TARGET_IDX, 32'd0);
        write_reg(CFG_STUTTER_IDX, 32'hFFFF_FFFF);
        send_tick(tick_cursor);
        send_tick(tick_cursor + 32'd1);
        send_tick(tick_cursor);
        drain_results;
        write_reg(CFG_TARGET_IDX, 32'hFFFF_FFFF);
        write_reg(CFG_STUTTER_IDX, 32'd0);
        send_tick(tick_cursor);
        send_tick(tick_cursor + 32'd1);
        drain_results;
        write_reg(CFG_LAST_UNUSED_IDX, $urandom);
        write_reg(CFG_IDX_W'($urandom_range(254, 2)), $urandom);
        send_tick(tick_cursor);
        drain_results;
        write_reg(CFG_TARGET_IDX, 32'd1);
        write_reg(CFG_STUTTER_IDX, 32'd16000);
        send_tick(tick_cursor);
        send_tick(tick_cursor + 32'd16);
        send_tick(tick_cursor + 32'd17);
        drain_results;
    endtask

    task automatic test_random_traffic(input int count, input int s_idle, input int r_idle);
        int          pick;
        logic [31:0] step_ms;
        write_reg(CFG_TARGET_IDX, $urandom_range(60000, 1000));
        write_reg(CFG_STUTTER_IDX, $urandom_range(60000, 0));
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        repeat (count) begin
            pick = $urandom_range(99, 0);
            if (pick < 60)
                step_ms = $urandom_range(20, 14);
            else if (pick < 72)
                step_ms = $urandom_range(60, 1);
            else if (pick < 80)
                step_ms = 32'd0;
            else if (pick < 88)
                step_ms = $urandom_range(100000, 61);
            else
                step_ms = $urandom;
            if (pick >= 95)
                send_tick($urandom);
            else
                send_tick(tick_cursor + step_ms);
        end
        drain_results;
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_first_frame_and_gaps;
        test_register_extremes;
        test_random_traffic(150, 37, 74);
        test_random_traffic(150, 74, 37);
        test_random_traffic(150, 0, 0);

        repeat (2 * RESULT_LATENCY) @(posedge i_clk);
        if (mismatches == 0)
            $display("frame_pacing_jitter_stats_tb: PASS");
        else
            $display("frame_pacing_jitter_stats_tb: FAIL");
        $finish;
    end

endmodule
`default_nettype wire
